@@ hw/rtl/lkv_pkg.sv @@
// Shared types and constants of the LRU key/value table.
package lkv_pkg;

   // Fixed field widths of the request and response transfers
   localparam int CMD_W      = 4;
   localparam int KEY_W      = 64;
   localparam int KLEN_W     = 4;
   localparam int VAL_W      = 32;
   localparam int OCC_W      = 5;
   localparam int CAP_W      = 5;
   localparam int REQ_DATA_W = CMD_W + KEY_W + KLEN_W + VAL_W;
   localparam int RSP_DATA_W = 72;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT       = 4'd0,
      CMD_GET       = 4'd1,
      CMD_LOOKUP    = 4'd2,
      CMD_TOUCH     = 4'd3,
      CMD_REMOVE    = 4'd4,
      CMD_POP_HEAD  = 4'd5,
      CMD_POP_TAIL  = 4'd6,
      CMD_PEEK_HEAD = 4'd7,
      CMD_PEEK_TAIL = 4'd8
   } lkv_cmd_type;

   // One result item
   typedef struct packed {
      logic [OCC_W-1:0] occupancy;
      logic [VAL_W-1:0] evicted_value;
      logic             evicted;
      logic [VAL_W-1:0] value_out;
      logic             found;
   } lkv_result_type;

   // Write enables of the entry memory
   typedef struct packed {
      logic entry_we;   // key, key length and value
      logic value_we;   // value only
      logic rank_we;    // recency rank
   } lkv_wr_ctl_type;

endpackage

@@ hw/rtl/lru_key_value_table_core.sv @@
// Top level of the LRU key/value table: stream ports, capacity register, result register.
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   req_tdata: command, key, key_length, value
//   rsp      out  rsp_tvalid / rsp_tready   rsp_tdata: found, value_out, evicted,
//                                           evicted_value, occupancy
//   csr      in   csr_valid / csr_ready     csr_data: capacity
//
// A command sweeps the entry memory once, one entry per cycle, through a single
// compare unit; a command that reorders, inserts or removes sweeps it a second
// time to rewrite ranks.
// Reset is synchronous: the table comes up empty and capacity reads 16.
// req_tready stays low while a command is in work; a stalled response holds
// the next finished result in the sequencer, and no new command is taken until it moves on.
module lru_key_value_table_core #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] command, [67:4] key, [71:68] key_length, [103:72] value
   input  logic [lkv_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] found, [32:1] value_out, [33] evicted, [65:34] evicted_value,
   // [70:66] occupancy, [71] zero
   output logic [lkv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]          csr_data
);
   import lkv_pkg::*;

   localparam int IW  = $clog2(ENTRIES);
   localparam int KB8 = KEY_BYTES * 8;
   localparam int LW  = $clog2(KEY_BYTES + 1);

   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  start;
   logic                  ctrl_idle;
   logic                  res_valid;
   logic                  res_ready;
   logic                  res_push;
   lkv_result_type        res;

   logic [IW-1:0]         ram_rd_addr;
   logic [KB8-1:0]        ram_rd_key;
   logic [LW-1:0]         ram_rd_len;
   logic [VALUE_BITS-1:0] ram_rd_value;
   logic [IW-1:0]         ram_rd_rank;
   lkv_wr_ctl_type        ram_wr_ctl;
   logic [IW-1:0]         ram_wr_addr;
   logic [KB8-1:0]        ram_wr_key;
   logic [LW-1:0]         ram_wr_len;
   logic [VALUE_BITS-1:0] ram_wr_value;
   logic [IW-1:0]         ram_wr_rank;

   // Take a request only while the sequencer is idle
   assign req_tready = ctrl_idle;
   assign start      = req_tvalid && req_tready;

   // Capacity register always takes the transfer
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   // Move a finished result into the output register when it has room
   assign res_ready = !rsp_tvalid_ff || rsp_tready;
   assign res_push  = res_valid && res_ready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_push) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, res.occupancy, res.evicted_value, res.evicted,
                          res.value_out, res.found};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   lkv_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BYTES  (KEY_BYTES),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .cmd          (req_tdata[3:0]),
      .key          (req_tdata[67:4]),
      .key_length   (req_tdata[71:68]),
      .value        (req_tdata[103:72]),
      .capacity     (capacity_ff),
      .idle         (ctrl_idle),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_key   (ram_rd_key),
      .ram_rd_len   (ram_rd_len),
      .ram_rd_value (ram_rd_value),
      .ram_rd_rank  (ram_rd_rank),
      .ram_wr_ctl   (ram_wr_ctl),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_key   (ram_wr_key),
      .ram_wr_len   (ram_wr_len),
      .ram_wr_value (ram_wr_value),
      .ram_wr_rank  (ram_wr_rank)
   );

   lkv_entry_ram #(
      .ENTRIES    (ENTRIES),
      .KEY_BYTES  (KEY_BYTES),
      .VALUE_BITS (VALUE_BITS)
   ) u_entry_ram (
      .clock    (clock),
      .rd_addr  (ram_rd_addr),
      .rd_key   (ram_rd_key),
      .rd_len   (ram_rd_len),
      .rd_value (ram_rd_value),
      .rd_rank  (ram_rd_rank),
      .wr_ctl   (ram_wr_ctl),
      .wr_addr  (ram_wr_addr),
      .wr_key   (ram_wr_key),
      .wr_len   (ram_wr_len),
      .wr_value (ram_wr_value),
      .wr_rank  (ram_wr_rank)
   );

`ifndef NO_ASSERTIONS
   // A taken request keeps the request side closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one is in work");

   // An eviction only comes with a put that missed
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.evicted) |-> !res.found)
      else $error("eviction reported together with a hit");

   // A miss carries a zero value_out
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res.found) |-> (res.value_out == '0))
      else $error("nonzero value on a miss");

   // Without an eviction the evicted value stays zero
   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res.evicted) |-> (res.evicted_value == '0))
      else $error("evicted value without an eviction");
`endif

endmodule

@@ hw/rtl/lkv_entry_ram.sv @@
// Entry memory: keys, key lengths, values and recency ranks, one port each way.
module lkv_entry_ram #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic [$clog2(ENTRIES)-1:0]         rd_addr,
   output logic [KEY_BYTES*8-1:0]             rd_key,
   output logic [$clog2(KEY_BYTES+1)-1:0]     rd_len,
   output logic [VALUE_BITS-1:0]              rd_value,
   output logic [$clog2(ENTRIES)-1:0]         rd_rank,
   input  lkv_pkg::lkv_wr_ctl_type            wr_ctl,
   input  logic [$clog2(ENTRIES)-1:0]         wr_addr,
   input  logic [KEY_BYTES*8-1:0]             wr_key,
   input  logic [$clog2(KEY_BYTES+1)-1:0]     wr_len,
   input  logic [VALUE_BITS-1:0]              wr_value,
   input  logic [$clog2(ENTRIES)-1:0]         wr_rank
);
   import lkv_pkg::*;

   localparam int IW  = $clog2(ENTRIES);
   localparam int KB8 = KEY_BYTES * 8;
   localparam int LW  = $clog2(KEY_BYTES + 1);

   logic [KB8-1:0]        key_mem   [ENTRIES];
   logic [LW-1:0]         len_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [IW-1:0]         rank_mem  [ENTRIES];

   logic [KB8-1:0]        rd_key_ff;
   logic [LW-1:0]         rd_len_ff;
   logic [VALUE_BITS-1:0] rd_value_ff;
   logic [IW-1:0]         rd_rank_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_ctl.entry_we) begin
         key_mem[wr_addr] <= wr_key;
         len_mem[wr_addr] <= wr_len;
      end
      if (wr_ctl.entry_we || wr_ctl.value_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_ctl.rank_we) begin
         rank_mem[wr_addr] <= wr_rank;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_len_ff   <= len_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
      rd_rank_ff  <= rank_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_len   = rd_len_ff;
   assign rd_value = rd_value_ff;
   assign rd_rank  = rd_rank_ff;

endmodule

@@ hw/rtl/lkv_ctrl.sv @@
// Sequencer: sweeps the entry memory with one shared compare and rank-adjust unit.
module lkv_ctrl #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [lkv_pkg::CMD_W-1:0]            cmd,
   input  logic [lkv_pkg::KEY_W-1:0]            key,
   input  logic [lkv_pkg::KLEN_W-1:0]           key_length,
   input  logic [lkv_pkg::VAL_W-1:0]            value,
   input  logic [lkv_pkg::CAP_W-1:0]            capacity,
   output logic                                 idle,
   output logic                                 res_valid,
   input  logic                                 res_ready,
   output lkv_pkg::lkv_result_type              res,
   output logic [$clog2(ENTRIES)-1:0]           ram_rd_addr,
   input  logic [KEY_BYTES*8-1:0]               ram_rd_key,
   input  logic [$clog2(KEY_BYTES+1)-1:0]       ram_rd_len,
   input  logic [VALUE_BITS-1:0]                ram_rd_value,
   input  logic [$clog2(ENTRIES)-1:0]           ram_rd_rank,
   output lkv_pkg::lkv_wr_ctl_type              ram_wr_ctl,
   output logic [$clog2(ENTRIES)-1:0]           ram_wr_addr,
   output logic [KEY_BYTES*8-1:0]               ram_wr_key,
   output logic [$clog2(KEY_BYTES+1)-1:0]       ram_wr_len,
   output logic [VALUE_BITS-1:0]                ram_wr_value,
   output logic [$clog2(ENTRIES)-1:0]           ram_wr_rank
);
   import lkv_pkg::*;

   localparam int IW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int KB8  = KEY_BYTES * 8;
   localparam int LW   = $clog2(KEY_BYTES + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE, OP_MOVE, OP_REMOVE, OP_INSERT
   } op_type;

   // What one sweep found
   typedef struct packed {
      logic                  hit;
      logic [IW-1:0]         hit_slot;
      logic [IW-1:0]         hit_rank;
      logic [VALUE_BITS-1:0] hit_val;
      logic                  rk;
      logic [IW-1:0]         rk_slot;
      logic [VALUE_BITS-1:0] rk_val;
      logic                  free;
      logic [IW-1:0]         free_slot;
   } scan_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [KB8-1:0]        key_ff, key_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  dat_vld_ff, dat_vld_in;
   logic [IW-1:0]         dat_idx_ff, dat_idx_in;
   scan_type              scan_ff, scan_in;
   logic [IW-1:0]         slot_ff, slot_in;
   logic [IW-1:0]         rank_ff, rank_in;
   logic                  put_hit_ff, put_hit_in;
   lkv_result_type        res_ff, res_in;
   logic [CW-1:0]         live_ff, live_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;

   logic [KLEN_W-1:0]     len_sat;
   logic [KEY_W-1:0]      key_masked;
   logic [IW-1:0]         rank_tgt;
   logic [CMPW-1:0]       cap_ext;
   logic [CMPW-1:0]       cap_eff;
   logic                  table_full;
   logic                  entry_valid;
   logic                  key_eq;
   logic                  rank_eq;

   // Normalize the incoming key: saturate the length, clear bytes beyond it
   always_comb begin
      len_sat = (key_length > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : key_length;
      for (int b = 0; b < 8; b++) begin
         key_masked[b*8 +: 8] = (KLEN_W'(b) < len_sat) ? key[b*8 +: 8] : 8'h00;
      end
   end

   // Effective capacity: zero acts as one, saturate at the table size
   always_comb begin
      cap_ext = CMPW'(capacity);
      if (cap_ext == '0) begin
         cap_eff = CMPW'(1);
      end else if (cap_ext > CMPW'(ENTRIES)) begin
         cap_eff = CMPW'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      table_full = (CMPW'(live_ff) >= cap_eff);
   end

   // Rank looked for during the sweep: head or tail
   assign rank_tgt = (cmd_ff == CMD_POP_HEAD || cmd_ff == CMD_PEEK_HEAD) ?
                     '0 : IW'(live_ff - CW'(1));

   // Shared compare unit on the entry that just came out of memory
   assign entry_valid = valid_ff[dat_idx_ff];
   assign key_eq  = entry_valid && (ram_rd_len == len_ff) && (ram_rd_key == key_ff);
   assign rank_eq = entry_valid && (ram_rd_rank == rank_tgt);

   always_comb begin
      logic          evict;
      logic [IW-1:0] new_slot;

      evict      = 1'b0;
      new_slot   = '0;
      state_in   = state_ff;
      op_in      = op_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      val_in     = val_ff;
      rd_idx_in  = rd_idx_ff;
      dat_vld_in = 1'b0;
      dat_idx_in = dat_idx_ff;
      scan_in    = scan_ff;
      slot_in    = slot_ff;
      rank_in    = rank_ff;
      put_hit_in = put_hit_ff;
      res_in     = res_ff;
      live_in    = live_ff;
      valid_in   = valid_ff;

      ram_rd_addr  = rd_idx_ff[IW-1:0];
      ram_wr_ctl   = '0;
      ram_wr_addr  = dat_idx_ff;
      ram_wr_key   = key_ff;
      ram_wr_len   = len_ff;
      ram_wr_value = val_ff;
      ram_wr_rank  = '0;

      // Advance the read pointer during both sweeps
      if (state_ff == ST_SCAN || state_ff == ST_UPDATE) begin
         if (rd_idx_ff != CW'(ENTRIES)) begin
            rd_idx_in  = rd_idx_ff + CW'(1);
            dat_vld_in = 1'b1;
            dat_idx_in = rd_idx_ff[IW-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               key_in    = KB8'(key_masked);
               len_in    = LW'(len_sat);
               val_in    = VALUE_BITS'(value);
               scan_in   = '0;
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Keep the first key hit, first rank hit and first free slot
            if (dat_vld_ff) begin
               if (key_eq && !scan_ff.hit) begin
                  scan_in.hit      = 1'b1;
                  scan_in.hit_slot = dat_idx_ff;
                  scan_in.hit_rank = ram_rd_rank;
                  scan_in.hit_val  = ram_rd_value;
               end
               if (rank_eq && !scan_ff.rk) begin
                  scan_in.rk      = 1'b1;
                  scan_in.rk_slot = dat_idx_ff;
                  scan_in.rk_val  = ram_rd_value;
               end
               if (!entry_valid && !scan_ff.free) begin
                  scan_in.free      = 1'b1;
                  scan_in.free_slot = dat_idx_ff;
               end
            end
            if (rd_idx_ff == CW'(ENTRIES) && !dat_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            res_in     = '0;
            op_in      = OP_NONE;
            put_hit_in = 1'b0;
            case (cmd_ff)
               CMD_PUT: begin
                  if (scan_ff.hit) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.hit_val);
                     op_in            = OP_MOVE;
                     slot_in          = scan_ff.hit_slot;
                     rank_in          = scan_ff.hit_rank;
                     put_hit_in       = 1'b1;
                  end else begin
                     evict = table_full && (live_ff != '0) && scan_ff.rk;
                     new_slot = (evict && (!scan_ff.free || scan_ff.rk_slot < scan_ff.free_slot))
                                ? scan_ff.rk_slot : scan_ff.free_slot;
                     if (evict) begin
                        res_in.evicted       = 1'b1;
                        res_in.evicted_value = VAL_W'(scan_ff.rk_val);
                        valid_in[scan_ff.rk_slot] = 1'b0;
                     end
                     if (evict || scan_ff.free) begin
                        valid_in[new_slot] = 1'b1;
                        op_in              = OP_INSERT;
                        slot_in            = new_slot;
                        if (!evict) begin
                           live_in = live_ff + CW'(1);
                        end
                     end
                  end
               end
               CMD_GET, CMD_TOUCH: begin
                  if (scan_ff.hit) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.hit_val);
                     op_in            = OP_MOVE;
                     slot_in          = scan_ff.hit_slot;
                     rank_in          = scan_ff.hit_rank;
                  end
               end
               CMD_LOOKUP: begin
                  if (scan_ff.hit) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.hit_val);
                  end
               end
               CMD_REMOVE: begin
                  if (scan_ff.hit) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.hit_val);
                     valid_in[scan_ff.hit_slot] = 1'b0;
                     live_in          = live_ff - CW'(1);
                     op_in            = OP_REMOVE;
                     rank_in          = scan_ff.hit_rank;
                  end
               end
               CMD_POP_HEAD, CMD_POP_TAIL: begin
                  if (live_ff != '0 && scan_ff.rk) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.rk_val);
                     valid_in[scan_ff.rk_slot] = 1'b0;
                     live_in          = live_ff - CW'(1);
                     op_in            = OP_REMOVE;
                     rank_in          = rank_tgt;
                  end
               end
               CMD_PEEK_HEAD, CMD_PEEK_TAIL: begin
                  if (live_ff != '0 && scan_ff.rk) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = VAL_W'(scan_ff.rk_val);
                  end
               end
               default: begin
               end
            endcase
            res_in.occupancy = OCC_W'(live_in);
            rd_idx_in        = '0;
            state_in         = (op_in == OP_NONE) ? ST_DONE : ST_UPDATE;
         end

         ST_UPDATE: begin
            // Rewrite ranks, and the new entry or value, one entry per cycle
            if (dat_vld_ff) begin
               case (op_ff)
                  OP_MOVE: begin
                     if (dat_idx_ff == slot_ff) begin
                        ram_wr_ctl.rank_we  = 1'b1;
                        ram_wr_ctl.value_we = put_hit_ff;
                        ram_wr_rank         = '0;
                     end else if (entry_valid && ram_rd_rank < rank_ff) begin
                        ram_wr_ctl.rank_we = 1'b1;
                        ram_wr_rank        = ram_rd_rank + IW'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (entry_valid && ram_rd_rank > rank_ff) begin
                        ram_wr_ctl.rank_we = 1'b1;
                        ram_wr_rank        = ram_rd_rank - IW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (dat_idx_ff == slot_ff) begin
                        ram_wr_ctl.entry_we = 1'b1;
                        ram_wr_ctl.rank_we  = 1'b1;
                        ram_wr_rank         = '0;
                     end else if (entry_valid) begin
                        ram_wr_ctl.rank_we = 1'b1;
                        ram_wr_rank        = ram_rd_rank + IW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (rd_idx_ff == CW'(ENTRIES) && !dat_vld_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, sweep pointers and the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         op_ff      <= OP_NONE;
         rd_idx_ff  <= '0;
         dat_vld_ff <= 1'b0;
         live_ff    <= '0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         rd_idx_ff  <= rd_idx_in;
         dat_vld_ff <= dat_vld_in;
         live_ff    <= live_in;
         valid_ff   <= valid_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      val_ff     <= val_in;
      dat_idx_ff <= dat_idx_in;
      scan_ff    <= scan_in;
      slot_ff    <= slot_in;
      rank_ff    <= rank_in;
      put_hit_ff <= put_hit_in;
      res_ff     <= res_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

@@ sim/lru_key_value_table_core_tb.sv @@
// Self-checking testbench for the LRU key/value table core.
`timescale 1ns / 100ps

module lru_key_value_table_core_tb;
   import lkv_pkg::*;

   localparam int SLOTS        = 16;
   localparam int KEY_BYTES_TB = 8;
   localparam int POOL_SIZE    = 24;
   localparam int NOT_HELD     = -1;
   localparam int PHASE_ITEMS  = 50;
   localparam logic [CMD_W-1:0] CMD_CODE_TOP = 4'hF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   // Shadow copy of the table contents and recency order
   logic [KEY_W-1:0]  tbl_key [SLOTS];
   logic [KLEN_W-1:0] tbl_klen [SLOTS];
   logic [VAL_W-1:0]  tbl_val [SLOTS];
   bit                tbl_live [SLOTS];
   int unsigned       tbl_rank [SLOTS];
   int unsigned       live_n = 0;
   logic [CAP_W-1:0]  cap_reg = CAP_RESET;

   // Keys reused by random traffic so that hits and evictions happen often
   logic [KEY_W-1:0]  pool_key [POOL_SIZE];
   logic [KLEN_W-1:0] pool_len [POOL_SIZE];

   lkv_result_type answers_due[$];
   lkv_result_type got_answer;
   lkv_result_type want_answer;

   int send_gap_pct = 9;
   int recv_gap_pct = 67;
   int rx_hold_req  = 0;
   int rx_hold_left = 0;
   int fail_count   = 0;
   int sent_count   = 0;
   int checked_count = 0;
   int evicted_seen = 0;
   int hits_seen    = 0;
   int cap_writes   = 0;

   lru_key_value_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Zero the key bytes beyond the significant length
   function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] key, logic [KLEN_W-1:0] len);
      if (len >= KEY_BYTES_TB) return key;
      if (len == 0) return '0;
      return key & ((64'd1 << (8 * len)) - 64'd1);
   endfunction

   function automatic int find_slot_by_key(logic [KEY_W-1:0] key, logic [KLEN_W-1:0] len);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_live[i] && tbl_klen[i] == len && tbl_key[i] == key) return i;
      return NOT_HELD;
   endfunction

   function automatic int find_slot_by_rank(int unsigned r);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_live[i] && tbl_rank[i] == r) return i;
      return NOT_HELD;
   endfunction

   // Move a slot to the head, shifting the more recent ones back by one
   function automatic void promote(int s);
      int unsigned r;
      r = tbl_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (tbl_live[i] && tbl_rank[i] < r) tbl_rank[i]++;
      tbl_rank[s] = 0;
   endfunction

   // Drop a slot and close the gap in the recency order
   function automatic void retire(int s);
      int unsigned r;
      r = tbl_rank[s];
      tbl_live[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_live[i] && tbl_rank[i] > r) tbl_rank[i]--;
      if (live_n > 0) live_n--;
   endfunction

   // Apply one command to the shadow table and return the answer it gives
   function automatic lkv_result_type predict_table_answer(logic [CMD_W-1:0] cmd,
         logic [KEY_W-1:0] key_in, logic [KLEN_W-1:0] len_in, logic [VAL_W-1:0] val);
      lkv_result_type ans;
      logic [KLEN_W-1:0] len;
      logic [KEY_W-1:0] key;
      int unsigned lim;
      int slot;
      int tail;
      ans = '0;
      len = (len_in > KEY_BYTES_TB) ? KLEN_W'(KEY_BYTES_TB) : len_in;
      key = trim_key(key_in, len);
      lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
      case (cmd)
         CMD_PUT: begin
            slot = find_slot_by_key(key, len);
            if (slot != NOT_HELD) begin
               ans.found = 1'b1;
               ans.value_out = tbl_val[slot];
               tbl_val[slot] = val;
               promote(slot);
            end else begin
               // evict the least recent entry once the limit is reached
               if (live_n >= lim && live_n > 0) begin
                  tail = find_slot_by_rank(live_n - 1);
                  if (tail != NOT_HELD) begin
                     ans.evicted = 1'b1;
                     ans.evicted_value = tbl_val[tail];
                     retire(tail);
                  end
               end
               // insert at the head into the lowest free slot
               slot = NOT_HELD;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!tbl_live[i]) begin
                     if (slot == NOT_HELD) slot = i;
                  end else begin
                     tbl_rank[i]++;
                  end
               end
               if (slot != NOT_HELD) begin
                  tbl_live[slot] = 1'b1;
                  tbl_key[slot]  = key;
                  tbl_klen[slot] = len;
                  tbl_val[slot]  = val;
                  tbl_rank[slot] = 0;
                  live_n++;
               end
            end
         end
         CMD_GET, CMD_LOOKUP, CMD_TOUCH, CMD_REMOVE: begin
            slot = find_slot_by_key(key, len);
            if (slot != NOT_HELD) begin
               ans.found = 1'b1;
               ans.value_out = tbl_val[slot];
               if (cmd == CMD_REMOVE) retire(slot);
               else if (cmd != CMD_LOOKUP) promote(slot);
            end
         end
         CMD_POP_HEAD, CMD_POP_TAIL, CMD_PEEK_HEAD, CMD_PEEK_TAIL: begin
            if (live_n > 0) begin
               slot = find_slot_by_rank((cmd == CMD_POP_HEAD || cmd == CMD_PEEK_HEAD) ?
                                        0 : live_n - 1);
               if (slot != NOT_HELD) begin
                  ans.found = 1'b1;
                  ans.value_out = tbl_val[slot];
                  if (cmd == CMD_POP_HEAD || cmd == CMD_POP_TAIL) retire(slot);
               end
            end
         end
         default: ;
      endcase
      ans.occupancy = OCC_W'(live_n);
      return ans;
   endfunction

   // Offer one request, hold it until the transfer, then queue its answer
   task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [KLEN_W-1:0] klen, input logic [VAL_W-1:0] val);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, klen, key, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answers_due.push_back(predict_table_answer(cmd, key, klen, val));
      sent_count++;
   endtask

   // Drop valid and wait until every queued answer has come back
   task automatic settle_outstanding();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cap_reg = cap;
      cap_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly pool keys, sometimes with junk above the length or an over-long length
   task automatic offer_random_request();
      int unsigned roll;
      int unsigned idx;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [KLEN_W-1:0] klen;
      roll = $urandom_range(0, 99);
      if (roll < 35)      cmd = CMD_PUT;
      else if (roll < 47) cmd = CMD_GET;
      else if (roll < 55) cmd = CMD_LOOKUP;
      else if (roll < 62) cmd = CMD_TOUCH;
      else if (roll < 72) cmd = CMD_REMOVE;
      else if (roll < 77) cmd = CMD_POP_HEAD;
      else if (roll < 82) cmd = CMD_POP_TAIL;
      else if (roll < 87) cmd = CMD_PEEK_HEAD;
      else if (roll < 92) cmd = CMD_PEEK_TAIL;
      else if (roll < 96) cmd = CMD_W'($urandom_range(CMD_PEEK_TAIL + 1, CMD_CODE_TOP));
      else                cmd = CMD_W'($urandom);
      idx  = $urandom_range(0, POOL_SIZE - 1);
      key  = pool_key[idx];
      klen = pool_len[idx];
      if ($urandom_range(0, 3) == 0) begin
         if (klen < KEY_BYTES_TB) key = key | ({$urandom, $urandom} << (8 * klen));
         else klen = KLEN_W'($urandom_range(KEY_BYTES_TB + 1, 15));
      end
      if ($urandom_range(0, 15) == 0) begin
         key  = {$urandom, $urandom};
         klen = KLEN_W'($urandom);
      end
      offer_request(cmd, key, klen, $urandom);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (rx_hold_req > 0) begin
         rx_hold_left = rx_hold_req;
         rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Compare each response transfer with the oldest queued answer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_answer = lkv_result_type'(rsp_tdata[$bits(lkv_result_type)-1:0]);
         if (answers_due.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want_answer = answers_due.pop_front();
            checked_count++;
            if (got_answer.evicted) evicted_seen++;
            if (got_answer.found) hits_seen++;
            if (got_answer.found !== want_answer.found) begin
               $error("found: expected %0d, got %0d", want_answer.found, got_answer.found);
               fail_count++;
            end
            if (got_answer.value_out !== want_answer.value_out) begin
               $error("value_out: expected %h, got %h",
                      want_answer.value_out, got_answer.value_out);
               fail_count++;
            end
            if (got_answer.evicted !== want_answer.evicted) begin
               $error("evicted: expected %0d, got %0d",
                      want_answer.evicted, got_answer.evicted);
               fail_count++;
            end
            if (got_answer.evicted_value !== want_answer.evicted_value) begin
               $error("evicted_value: expected %h, got %h",
                      want_answer.evicted_value, got_answer.evicted_value);
               fail_count++;
            end
            if (got_answer.occupancy !== want_answer.occupancy) begin
               $error("occupancy: expected %0d, got %0d",
                      want_answer.occupancy, got_answer.occupancy);
               fail_count++;
            end
         end
      end
   end

   // Field extremes, every command, key identity rules and capacity zero
   task automatic test_directed_cases();
      offer_request(CMD_PEEK_HEAD, '0, 4'd1, $urandom);
      offer_request(CMD_POP_TAIL, '0, 4'd1, $urandom);
      offer_request(CMD_GET, 64'hA5, 4'd1, $urandom);
      offer_request(CMD_PUT, '0, 4'd0, 32'h0);
      offer_request(CMD_PUT, '1, 4'd8, 32'hFFFF_FFFF);
      // length above eight names the same eight-byte key
      offer_request(CMD_PUT, '1, 4'd15, 32'h0000_0001);
      offer_request(CMD_PUT, 64'hDEAD_BEEF_CAFE_F0A5, 4'd1, 32'h1234_5678);
      offer_request(CMD_GET, 64'hA5, 4'd1, $urandom);
      // same byte, other length: a different key
      offer_request(CMD_GET, 64'hA5, 4'd2, $urandom);
      // empty key ignores every key bit
      offer_request(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd0, $urandom);
      offer_request(CMD_TOUCH, '1, 4'd8, $urandom);
      offer_request(CMD_PEEK_HEAD, '0, 4'd0, $urandom);
      offer_request(CMD_PEEK_TAIL, '0, 4'd0, $urandom);
      offer_request(CMD_REMOVE, 64'hA5, 4'd1, $urandom);
      offer_request(CMD_REMOVE, 64'hA5, 4'd1, $urandom);
      offer_request(CMD_W'(CMD_PEEK_TAIL + 1), '1, 4'd8, $urandom);
      offer_request(CMD_CODE_TOP, '1, 4'd8, $urandom);
      offer_request(CMD_POP_HEAD, '0, 4'd0, $urandom);
      offer_request(CMD_POP_TAIL, '0, 4'd0, $urandom);
      offer_request(CMD_POP_TAIL, '0, 4'd0, $urandom);
      offer_request(CMD_PEEK_TAIL, '0, 4'd0, $urandom);
      // capacity zero behaves as one: the second put evicts the first
      settle_outstanding();
      write_capacity(5'd0);
      offer_request(CMD_PUT, 64'h11, 4'd1, 32'hAAAA_5555);
      offer_request(CMD_PUT, 64'h22, 4'd1, 32'h5555_AAAA);
      offer_request(CMD_GET, 64'h11, 4'd1, $urandom);
      settle_outstanding();
   endtask

   // Hold the receiver off long enough that the core stalls its request side
   task automatic test_result_backpressure();
      write_capacity(CAP_RESET);
      send_gap_pct = 0;
      recv_gap_pct = 0;
      rx_hold_req = 400;
      repeat (12) offer_random_request();
      settle_outstanding();
   endtask

   // Random traffic over several capacities, including lowering it below occupancy
   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [8];
      caps = '{5'd16, 5'd31, 5'd2, 5'd17, 5'd0, 5'd5, 5'd1, 5'd8};
      for (int p = 0; p < 8; p++) begin
         if (p < 3) begin
            send_gap_pct = 9;
            recv_gap_pct = 67;
         end else if (p < 6) begin
            send_gap_pct = 67;
            recv_gap_pct = 9;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         write_capacity(caps[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause the sender midway until the core has answered everything
            if (n == PHASE_ITEMS / 2) settle_outstanding();
            offer_random_request();
         end
         settle_outstanding();
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
      // odd pool entries reuse the previous bytes under a length of their own
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_len[i] = KLEN_W'($urandom_range(0, KEY_BYTES_TB));
         pool_key[i] = trim_key((i % 2 == 1) ? pool_key[i-1] : {$urandom, $urandom},
                                pool_len[i]);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_result_backpressure();
      test_random_traffic();

      settle_outstanding();
      repeat (60) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses (%0d hits, %0d evictions)",
               sent_count, checked_count, hits_seen, evicted_seen);
      $display("Capacity written %0d times, including zero, one, sixteen and saturating values",
               cap_writes);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(2_000_000);
      $display("Timeout with %0d responses still outstanding", answers_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
